// File: hdl/spe_pkg.sv
// shared types and constants of the selectable prng engine
package spe_pkg;

   // algorithm codes
   localparam logic [1:0] GEN_LCG = 2'd0;
   localparam logic [1:0] GEN_XS  = 2'd1;
   localparam logic [1:0] GEN_PCG = 2'd2;
   localparam logic [1:0] GEN_SM  = 2'd3;

   // configuration register indexes
   localparam logic CSR_GEN_TYPE = 1'b0;
   localparam logic CSR_SEED     = 1'b1;

   // generator constants
   localparam logic [63:0] LCG_MOD = 64'd2147483647;
   localparam logic [63:0] LCG_MUL = 64'd48271;
   localparam logic [63:0] XS_ZERO = 64'h0000_0BAD_F00D_1234;
   localparam logic [63:0] XS_MUL  = 64'd2685821657736338717;
   localparam logic [63:0] PCG_MUL = 64'd6364136223846793005;
   localparam logic [63:0] GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] SM_MUL1 = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] SM_MUL2 = 64'h94D0_49BB_1331_11EB;

   // start of a shared arithmetic unit
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } unit_req_type;

   // completion of a shared arithmetic unit
   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } unit_rsp_type;

endpackage

// File: hdl/spe_channels.sv
// request and response channel interfaces of the selectable prng engine

interface spe_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [63:0] modulus;
   modport source (output valid, output cmd, output modulus, input ready);
   modport sink (input valid, input cmd, input modulus, output ready);
endinterface

interface spe_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// File: hdl/selectable_prng_engine.sv
// top level: sequencer of the selectable prng engine around shared mul and div units
// restart: seeds the state directly for lcg, xorshift64* and splitmix64, and runs two multiplier steps for pcg32;
// draw: raw value from the multiplier, then through the remainder unit when modulus is nonzero
// one request at a time; no new request is taken until the response has been handed off
// reset: synchronous, active high; state seeded as splitmix64 from seed zero
module selectable_prng_engine import spe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   spe_req_if.sink     req_ch,
   spe_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_PCG_MUL, S_LCG_MUL, S_XS_MUL, S_SM_MUL1, S_SM_MUL2, S_MOD_DIV
   } state_type;

   state_type    state_ff, state_in;
   logic [1:0]   gen_type_ff, gen_type_in;
   logic [63:0]  seed_ff, seed_in;
   logic [63:0]  gstate_ff, gstate_in;
   logic [63:0]  inc_ff, inc_in;
   logic [1:0]   active_ff, active_in;
   logic [63:0]  mod_ff, mod_in;
   logic         seeding_ff, seeding_in;
   logic         step2_ff, step2_in;
   logic [31:0]  hi_ff, hi_in;
   logic [31:0]  lo_ff, lo_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_value_ff, rsp_value_in;

   unit_req_type mul_req;
   unit_rsp_type mul_rsp;
   unit_req_type div_req;
   unit_rsp_type div_rsp;

   logic         req_fire;
   logic         fin_go;
   logic [63:0]  fin_val;
   logic [63:0]  xs_x;
   logic [63:0]  sm_z;
   logic [63:0]  pcg_next;
   logic [32:0]  lcg_fold;
   logic [32:0]  lcg_red;
   logic [32:0]  seed_fold;
   logic [31:0]  seed_sum2;
   logic [30:0]  seed_red;

   // pcg32 output permutation of a state
   function automatic logic [31:0] pcg_out(input logic [63:0] s);
      logic [31:0] mixed;
      logic [63:0] both;
      mixed = 32'(((s >> 18) ^ s) >> 27);
      both  = {mixed, mixed} >> s[63:59];
      return both[31:0];
   endfunction

   spe_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   spe_div64 u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = rsp_value_ff;

   // small datapath pieces
   always_comb begin
      xs_x     = gstate_ff ^ (gstate_ff >> 12);
      xs_x     = xs_x ^ (xs_x << 25);
      xs_x     = xs_x ^ (xs_x >> 27);
      sm_z     = gstate_ff + GOLDEN;
      pcg_next = mul_rsp.result + inc_ff + ((seeding_ff && !step2_ff) ? seed_ff : 64'd0);
      lcg_fold = {2'b00, mul_rsp.result[30:0]} + mul_rsp.result[63:31];
      if (lcg_fold >= LCG_MOD[32:0]) begin
         lcg_red = lcg_fold - LCG_MOD[32:0];
      end else begin
         lcg_red = lcg_fold;
      end
      // seed mod 2^31-1 by folding 31-bit chunks, since 2^31 is 1 in that ring
      seed_fold = {2'b00, seed_ff[30:0]} + {2'b00, seed_ff[61:31]}
                  + {31'd0, seed_ff[63:62]};
      seed_sum2 = {1'b0, seed_fold[30:0]} + {30'd0, seed_fold[32:31]};
      if (seed_sum2 >= LCG_MOD[31:0]) begin
         seed_red = 31'(seed_sum2 - LCG_MOD[31:0]);
      end else begin
         seed_red = seed_sum2[30:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      gen_type_in  = gen_type_ff;
      seed_in      = seed_ff;
      gstate_in    = gstate_ff;
      inc_in       = inc_ff;
      active_in    = active_ff;
      mod_in       = mod_ff;
      seeding_in   = seeding_ff;
      step2_in     = step2_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      mul_req      = '{start: 1'b0, a: gstate_ff, b: PCG_MUL};
      div_req      = '{start: 1'b0, a: seed_ff, b: LCG_MOD};
      fin_go       = 1'b0;
      fin_val      = mul_rsp.result;

      // configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GEN_TYPE: gen_type_in = csr_wr_data[1:0];
            CSR_SEED:     seed_in     = csr_wr_data;
            default:      seed_in     = seed_ff;
         endcase
      end

      // response handoff
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mod_in = req_ch.modulus;
               if (req_ch.cmd) begin
                  active_in = gen_type_ff;
                  inc_in    = 64'd0;
                  case (gen_type_ff)
                     GEN_LCG: begin
                        gstate_in = (seed_red == 31'd0) ? 64'd1 : {33'd0, seed_red};
                     end
                     GEN_XS: begin
                        gstate_in = (seed_ff != 64'd0) ? seed_ff : XS_ZERO;
                     end
                     GEN_PCG: begin
                        inc_in     = {seed_ff[62:0], 1'b1};
                        gstate_in  = 64'd0;
                        seeding_in = 1'b1;
                        step2_in   = 1'b0;
                        mul_req    = '{start: 1'b1, a: 64'd0, b: PCG_MUL};
                        state_in   = S_PCG_MUL;
                     end
                     default: begin
                        gstate_in = seed_ff + GOLDEN;
                     end
                  endcase
               end else begin
                  case (active_ff)
                     GEN_LCG: begin
                        mul_req  = '{start: 1'b1, a: gstate_ff, b: LCG_MUL};
                        state_in = S_LCG_MUL;
                     end
                     GEN_XS: begin
                        gstate_in = xs_x;
                        mul_req   = '{start: 1'b1, a: xs_x, b: XS_MUL};
                        state_in  = S_XS_MUL;
                     end
                     GEN_PCG: begin
                        seeding_in = 1'b0;
                        step2_in   = 1'b0;
                        hi_in      = pcg_out(gstate_ff);
                        mul_req    = '{start: 1'b1, a: gstate_ff, b: PCG_MUL};
                        state_in   = S_PCG_MUL;
                     end
                     default: begin
                        gstate_in = sm_z;
                        mul_req   = '{start: 1'b1, a: sm_z ^ (sm_z >> 30), b: SM_MUL1};
                        state_in  = S_SM_MUL1;
                     end
                  endcase
               end
            end
         end
         S_PCG_MUL: begin
            if (mul_rsp.done) begin
               gstate_in = pcg_next;
               if (!step2_ff) begin
                  step2_in = 1'b1;
                  lo_in    = pcg_out(pcg_next);
                  mul_req  = '{start: 1'b1, a: pcg_next, b: PCG_MUL};
               end else if (seeding_ff) begin
                  state_in = S_IDLE;
               end else begin
                  fin_go  = 1'b1;
                  fin_val = {hi_ff, lo_ff};
               end
            end
         end
         S_LCG_MUL: begin
            if (mul_rsp.done) begin
               gstate_in = {31'd0, lcg_red};
               fin_go    = 1'b1;
               fin_val   = {31'd0, lcg_red};
            end
         end
         S_XS_MUL: begin
            if (mul_rsp.done) begin
               fin_go = 1'b1;
            end
         end
         S_SM_MUL1: begin
            if (mul_rsp.done) begin
               mul_req  = '{start: 1'b1, a: mul_rsp.result ^ (mul_rsp.result >> 27),
                            b: SM_MUL2};
               state_in = S_SM_MUL2;
            end
         end
         S_SM_MUL2: begin
            if (mul_rsp.done) begin
               fin_go  = 1'b1;
               fin_val = mul_rsp.result ^ (mul_rsp.result >> 31);
            end
         end
         S_MOD_DIV: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = div_rsp.result;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // optional reduction of a finished raw value
      if (fin_go) begin
         if (mod_ff != 64'd0) begin
            div_req  = '{start: 1'b1, a: fin_val, b: mod_ff};
            state_in = S_MOD_DIV;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_value_in = fin_val;
            state_in     = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_type_ff  <= GEN_SM;
         seed_ff      <= 64'd0;
         gstate_ff    <= GOLDEN;
         inc_ff       <= 64'd0;
         active_ff    <= GEN_SM;
         seeding_ff   <= 1'b0;
         step2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_type_ff  <= gen_type_in;
         seed_ff      <= seed_in;
         gstate_ff    <= gstate_in;
         inc_ff       <= inc_in;
         active_ff    <= active_in;
         seeding_ff   <= seeding_in;
         step2_ff     <= step2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mod_ff       <= mod_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

// File: hdl/spe_mul64.sv
// 64x64 low-half multiplier built from one 32x32 multiplier over four steps
module spe_mul64 import spe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  unit_req_type mul_req,
   output unit_rsp_type mul_rsp
);

   logic        busy_ff, busy_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic        done_ff, done_in;
   logic [31:0] op_a;
   logic [31:0] op_b;

   // operand selection per partial product
   always_comb begin
      case (step_ff)
         2'd0: begin
            op_a = a_ff[31:0];
            op_b = b_ff[31:0];
         end
         2'd1: begin
            op_a = a_ff[31:0];
            op_b = b_ff[63:32];
         end
         default: begin
            op_a = a_ff[63:32];
            op_b = b_ff[31:0];
         end
      endcase
   end

   // step sequencing and accumulation
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      prod_in = {32'd0, op_a} * {32'd0, op_b};
      if (mul_req.start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         a_in    = mul_req.a;
         b_in    = mul_req.b;
         acc_in  = 64'd0;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = acc_ff + prod_ff;
            default: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         endcase
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign mul_rsp.done   = done_ff;
   assign mul_rsp.result = acc_ff;

endmodule

// File: hdl/spe_div64.sv
// 64-bit restoring remainder unit, one quotient bit per cycle
module spe_div64 import spe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  unit_req_type div_req,
   output unit_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] rem_ff, rem_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[63]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd64;
         num_in  = div_req.a;
         den_in  = div_req.b;
         rem_in  = 64'd0;
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 64'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[63:0];
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 7'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.result = rem_ff;

endmodule

// File: verif/spe_checker.sv
// passive checker: predicts each drawn value of the prng engine and compares responses
module spe_checker import spe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   spe_req_if          req_ch,
   spe_rsp_if          rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wr_data,
   output int          fail_count,
   output int          values_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow registers and generator state
   logic [1:0]  cfg_type;
   logic [63:0] cfg_seed;
   logic [1:0]  live_type;
   logic [63:0] prng_state;
   logic [63:0] pcg_inc;
   logic [63:0] value_q[$];

   // one pcg32 output, advancing the state
   function automatic logic [31:0] pcg_next();
      logic [63:0] prev;
      logic [31:0] mixed;
      logic [4:0]  rot;
      prev = prng_state;
      prng_state = prev * PCG_MUL + pcg_inc;
      mixed = 32'(((prev >> 18) ^ prev) >> 27);
      rot = prev[63:59];
      if (rot == 0) return mixed;
      return (mixed >> rot) | (mixed << (6'd32 - rot));
   endfunction

   // seed the state from the shadow registers and latch the algorithm
   task automatic restart_gen();
      logic [31:0] unused;
      live_type = cfg_type;
      pcg_inc = '0;
      case (live_type)
         GEN_LCG: begin
            prng_state = cfg_seed % LCG_MOD;
            if (prng_state == 0) prng_state = 1;
         end
         GEN_XS: begin
            prng_state = (cfg_seed != 0) ? cfg_seed : XS_ZERO;
         end
         GEN_PCG: begin
            prng_state = '0;
            pcg_inc = {cfg_seed[62:0], 1'b1};
            unused = pcg_next();
            prng_state = prng_state + cfg_seed;
            unused = pcg_next();
         end
         default: begin
            prng_state = cfg_seed + GOLDEN;
         end
      endcase
   endtask

   // next raw value of the latched algorithm
   function automatic logic [63:0] draw_value();
      logic [63:0] x;
      logic [31:0] hi;
      case (live_type)
         GEN_LCG: begin
            prng_state = (prng_state * LCG_MUL) % LCG_MOD;
            return prng_state;
         end
         GEN_XS: begin
            x = prng_state;
            x = x ^ (x >> 12);
            x = x ^ (x << 25);
            x = x ^ (x >> 27);
            prng_state = x;
            return x * XS_MUL;
         end
         GEN_PCG: begin
            hi = pcg_next();
            return {hi, pcg_next()};
         end
         default: begin
            prng_state = prng_state + GOLDEN;
            x = prng_state;
            x = (x ^ (x >> 30)) * SM_MUL1;
            x = (x ^ (x >> 27)) * SM_MUL2;
            return x ^ (x >> 31);
         end
      endcase
   endfunction

   initial begin
      fail_count = 0;
      values_pending = 0;
   end

   // watch both channels and the register port
   always @(posedge clock) begin
      logic [63:0] v;
      logic [63:0] want;
      if (reset) begin
         cfg_type = GEN_SM;
         cfg_seed = '0;
         restart_gen();
         value_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_GEN_TYPE) cfg_type = csr_wr_data[1:0];
            else cfg_seed = csr_wr_data;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (value_q.size() == 0) begin
               $display("%0t: unexpected response value %h", $time, rsp_ch.value);
               fail_count++;
            end else begin
               want = value_q.pop_front();
               if (rsp_ch.value !== want) begin
                  $display("%0t: value mismatch expected %h actual %h",
                           $time, want, rsp_ch.value);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.cmd) begin
               restart_gen();
            end else begin
               v = draw_value();
               if (req_ch.modulus != 0) v = v % req_ch.modulus;
               value_q.push_back(v);
            end
         end
      end
      values_pending = value_q.size();
   end
endmodule

// File: verif/tb_selectable_prng_engine.sv
// testbench top: stimulus, register writes, flow control and verdict for the prng engine
module tb_selectable_prng_engine;
   import spe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 100;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [63:0] csr_wr_data;
   int          fail_count;
   int          values_pending;
   bit          idle_on;
   bit          hold_req;
   int          n_draws;
   int          n_restarts;
   int          n_writes;

   spe_req_if req_ch();
   spe_rsp_if rsp_ch();

   selectable_prng_engine u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   spe_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .values_pending(values_pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // response side flow control, with one long hold-off on request
   initial begin
      bit held;
      held = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            held = 1;
            rsp_ch.ready = 1'b0;
            repeat (400) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // send one request; returns at a falling edge with valid still high
   task automatic send_req(logic cmd, logic [63:0] modulus);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.cmd = cmd;
      req_ch.modulus = modulus;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (cmd) n_restarts++;
      else n_draws++;
   endtask

   // wait until every value has come back and the engine has settled
   task automatic drain();
      req_ch.valid = 1'b0;
      while (values_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write, only called while idle
   task automatic write_reg(logic index, logic [63:0] data);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      n_writes++;
   endtask

   // mostly raw or small bounds, sometimes wide or extreme ones
   function automatic logic [63:0] pick_modulus();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return '0;
         4:          return 64'($urandom_range(1, 16));
         5:          return {32'd0, $urandom()};
         6:          return {$urandom(), $urandom()};
         7:          return 64'd1 << $urandom_range(0, 63);
         8:          return '1;
         default:    return {$urandom(), $urandom()} >> $urandom_range(0, 63);
      endcase
   endfunction

   // stimulus
   initial begin
      int phase_len;
      reset = 1'b1;
      idle_on = 1;
      hold_req = 0;
      n_draws = 0;
      n_restarts = 0;
      n_writes = 0;
      req_ch.valid = 1'b0;
      req_ch.cmd = 1'b0;
      req_ch.modulus = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_GEN_TYPE;
      csr_wr_data = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // draws from the reset seeding, with extreme bounds
      send_req(1'b0, '0);
      send_req(1'b0, 64'd1);
      send_req(1'b0, '1);
      send_req(1'b0, 64'h8000_0000_0000_0000);
      drain();

      // lcg with zero seed turning into one, then a seed equal to the modulus
      write_reg(CSR_GEN_TYPE, {62'd0, GEN_LCG});
      write_reg(CSR_SEED, '0);
      send_req(1'b1, '1);
      send_req(1'b0, '0);
      send_req(1'b0, 64'd7);
      drain();
      write_reg(CSR_SEED, LCG_MOD);
      send_req(1'b1, '0);
      send_req(1'b0, '0);
      drain();

      // type and seed changed without restart keep the latched lcg
      write_reg(CSR_GEN_TYPE, {62'd0, GEN_XS});
      write_reg(CSR_SEED, 64'h1234_5678);
      send_req(1'b0, '0);
      send_req(1'b0, '0);
      drain();

      // xorshift with zero seed, pcg and splitmix with all-ones seed
      write_reg(CSR_SEED, '0);
      send_req(1'b1, '0);
      send_req(1'b0, '0);
      send_req(1'b0, 64'd1000);
      drain();
      write_reg(CSR_GEN_TYPE, {62'd0, GEN_PCG});
      write_reg(CSR_SEED, '1);
      send_req(1'b1, '0);
      send_req(1'b0, '0);
      send_req(1'b0, '1);
      drain();
      write_reg(CSR_GEN_TYPE, {62'd0, GEN_SM});
      send_req(1'b1, '0);
      send_req(1'b0, '0);
      send_req(1'b0, 64'hFFFF_FFFF);
      drain();

      // random phases: new settings, a restart, then mostly draws
      while (n_draws + n_restarts < 720) begin
         if (n_draws + n_restarts > 620) idle_on = 0;
         write_reg(CSR_GEN_TYPE, 64'($urandom_range(0, 3)));
         case ($urandom_range(0, 4))
            0:       write_reg(CSR_SEED, '0);
            1:       write_reg(CSR_SEED, '1);
            2:       write_reg(CSR_SEED, 64'($urandom_range(0, 100)));
            default: write_reg(CSR_SEED, {$urandom(), $urandom()});
         endcase
         send_req(1'b1, pick_modulus());
         phase_len = $urandom_range(10, 40);
         repeat (phase_len) begin
            if (n_draws + n_restarts > 300 && !hold_req) hold_req = 1;
            send_req(($urandom_range(0, 9) == 0), pick_modulus());
         end
         drain();
      end

      $display("covered %0d draws and %0d restarts over %0d register writes,",
               n_draws, n_restarts, n_writes);
      $display("all four algorithms, raw and bounded values, one long response hold-off");
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
